@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL. Each macro expects signals named clk
// and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ARC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition that must never be seen outside reset.
`define ARC_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ARC_ASSERT(lbl, prop)
`define ARC_NEVER(lbl, cond)
`endif
`endif

@@ rtl/core/arc_pkg.sv @@
// ============================================================================
// ARP resolution cache package
// Shared constants, codes and the structures passed between the cells and
// the controller.
// ============================================================================
package arc_pkg;

    // One cell carries one cache, one hold and one pending entry.
    localparam int ARC_CELLS = 16;
    localparam int CELL_IW   = $clog2(ARC_CELLS);

    localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [15:0] ARP_OP_REQ = 16'd1;

    localparam logic [31:0] TTL_RESET  = 32'd30000;
    localparam logic [31:0] HOLD_RESET = 32'd5000;

    typedef enum logic [1:0] {
        FUNC_SEND = 2'd0,
        FUNC_RX   = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NOP  = 2'd3
    } arc_func_t;

    typedef enum logic [1:0] {
        REG_OWN_MAC = 2'd0,
        REG_OWN_IP  = 2'd1,
        REG_TTL     = 2'd2,
        REG_HOLD    = 2'd3
    } arc_reg_t;

    typedef enum logic [2:0] {
        ACT_SEND    = 3'd0,
        ACT_REQUEST = 3'd1,
        ACT_REPLY   = 3'd2,
        ACT_DELIVER = 3'd3,
        ACT_DROP    = 3'd4
    } arc_action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_HSCAN,
        S_HFILL,
        S_REQ,
        S_PARK,
        S_CSCAN,
        S_CFILL,
        S_REL,
        S_RSCAN,
        S_RELEMIT,
        S_REPLY,
        S_TICK_ADD,
        S_TICK_EXP
    } arc_state_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic [31:0] q_ip;
        logic [47:0] mac;
        logic [63:0] cache_exp;
        logic [63:0] hold_until;
        logic [15:0] handle;
        logic [15:0] stamp;
        logic [63:0] now;
        logic        tick;
    } arc_cmd_t;

    // Per-cell write strobes.
    typedef struct packed {
        logic cache_we;
        logic hold_we;
        logic pend_we;
        logic pend_clr;
    } arc_we_t;

    // Passed from cell to cell: a free entry was seen further up the row.
    typedef struct packed {
        logic cache_seen;
        logic hold_seen;
        logic pend_seen;
    } arc_chain_t;

    typedef struct packed {
        logic        cache_hit;
        logic        hold_hit;
        logic        pend_hit;
        logic        cache_first_free;
        logic        hold_first_free;
        logic        pend_first_free;
        logic [47:0] cache_mac;
        logic [63:0] cache_exp;
        logic [63:0] hold_until;
        logic [15:0] pend_handle;
        logic [15:0] pend_stamp;
    } arc_stat_t;

endpackage

@@ rtl/core/arp_resolution_cache.sv @@
// A hit, a delivery, a filtered frame or an unused code finishes in the decode state; a
// tick adds the elapsed time and then expires entries; a miss inside the hold window
// parks the item, otherwise it writes a hold entry, scanning a full hold table first, and
// sends a request; an ARP frame scans a full cache, releases parked items one by one, may reply.
// A hit's result is registered from the decode state; a stalled result holds the block there.
// One item is in flight at a time; reset clears valid bits, the clock and the stamp counter.
// ============================================================================
// ARP resolution cache
// Controller and row of cells: resolves next hops, parks items on a miss,
// learns mappings from ARP frames and releases parked items oldest first.
// ============================================================================
`include "assert_macros.svh"
module arp_resolution_cache
    import arc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] next_hop_ip,
    input  logic [15:0] packet_handle,
    input  logic [47:0] frame_dst_mac,
    input  logic [15:0] frame_type,
    input  logic [15:0] arp_opcode,
    input  logic [47:0] arp_sender_mac,
    input  logic [31:0] arp_sender_ip,
    input  logic [31:0] arp_target_ip,
    input  logic [15:0] elapsed_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [47:0] dst_mac,
    output logic [31:0] dest_ip,
    output logic [15:0] out_handle,
    output logic        last
);

    arc_state_t  state_reg, state_next;
    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg, ttl_reg, hold_ms_reg;
    logic [63:0] now_reg, now_next;
    logic [15:0] stamp_reg, stamp_next;

    logic [1:0]  func_reg;
    logic [31:0] q_ip_reg;
    logic [15:0] handle_reg;
    logic [47:0] fdst_reg;
    logic [15:0] ftype_reg;
    logic [15:0] opcode_reg;
    logic [47:0] smac_reg;
    logic [31:0] tip_reg;
    logic [15:0] elapsed_reg;

    logic [CELL_IW-1:0] cur_reg, cur_next;
    logic [CELL_IW-1:0] best_idx_reg, best_idx_next;
    logic               best_found_reg, best_found_next;
    logic [63:0]        best_val_reg, best_val_next;
    logic [15:0]        best_age_reg, best_age_next;

    logic        out_valid_reg;
    arc_action_t out_action_reg;
    logic [47:0] out_mac_reg;
    logic [31:0] out_ip_reg;
    logic [15:0] out_handle_reg;
    logic        out_last_reg;

    logic        emit_en;
    arc_action_t emit_action;
    logic [47:0] emit_mac;
    logic [31:0] emit_ip;
    logic [15:0] emit_handle;
    logic        emit_last;
    logic        out_free;

    arc_cmd_t   cmd;
    arc_we_t    we_arr [ARC_CELLS];
    arc_chain_t chain [ARC_CELLS+1];
    arc_stat_t  stat_arr [ARC_CELLS];

    logic [ARC_CELLS-1:0] cache_hit_vec, hold_hit_vec, pend_hit_vec;
    logic [47:0]          hit_mac;
    logic [63:0]          hit_until;
    logic [CELL_IW-1:0]   cache_hit_idx, hold_hit_idx;
    logic [CELL_IW-1:0]   cache_free_idx, hold_free_idx, pend_free_idx;
    logic                 cache_free_any, hold_free_any, pend_free_any;
    logic [15:0]          cur_age;
    logic                 reply_due;
    logic                 cur_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // Row of cells with the free-entry search rippling along it.
    assign chain[0] = '0;
    for (genvar g = 0; g < ARC_CELLS; g++)
    begin : g_cell
        arc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .we        (we_arr[g]),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .stat      (stat_arr[g])
        );
    end

    assign cache_free_any = chain[ARC_CELLS].cache_seen;
    assign hold_free_any  = chain[ARC_CELLS].hold_seen;
    assign pend_free_any  = chain[ARC_CELLS].pend_seen;

    // Gather hit flags and encode the matching and lowest free entries.
    always_comb
    begin
        hit_mac        = '0;
        hit_until      = '0;
        cache_hit_idx  = '0;
        hold_hit_idx   = '0;
        cache_free_idx = '0;
        hold_free_idx  = '0;
        pend_free_idx  = '0;
        for (int i = 0; i < ARC_CELLS; i++)
        begin
            cache_hit_vec[i] = stat_arr[i].cache_hit;
            hold_hit_vec[i]  = stat_arr[i].hold_hit;
            pend_hit_vec[i]  = stat_arr[i].pend_hit;
            if (stat_arr[i].cache_hit)
            begin
                hit_mac       = hit_mac | stat_arr[i].cache_mac;
                cache_hit_idx = cache_hit_idx | CELL_IW'(i);
            end
            if (stat_arr[i].hold_hit)
            begin
                hit_until    = hit_until | stat_arr[i].hold_until;
                hold_hit_idx = hold_hit_idx | CELL_IW'(i);
            end
            if (stat_arr[i].cache_first_free)
                cache_free_idx = cache_free_idx | CELL_IW'(i);
            if (stat_arr[i].hold_first_free)
                hold_free_idx = hold_free_idx | CELL_IW'(i);
            if (stat_arr[i].pend_first_free)
                pend_free_idx = pend_free_idx | CELL_IW'(i);
        end
    end

    assign cur_age   = stamp_reg - stat_arr[cur_reg].pend_stamp;
    assign reply_due = (opcode_reg == ARP_OP_REQ) && (tip_reg == own_ip_reg);
    assign cur_last  = (cur_reg == CELL_IW'(ARC_CELLS - 1));

    // Broadcast write data for the cells.
    always_comb
    begin
        cmd.q_ip       = q_ip_reg;
        cmd.mac        = smac_reg;
        cmd.cache_exp  = now_reg + 64'(ttl_reg);
        cmd.hold_until = now_reg + 64'(hold_ms_reg);
        cmd.handle     = handle_reg;
        cmd.stamp      = stamp_reg;
        cmd.now        = now_reg;
        cmd.tick       = (state_reg == S_TICK_EXP);
    end

    // Sequencer: next state, scan registers, write strobes and results.
    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        stamp_next      = stamp_reg;
        cur_next        = cur_reg;
        best_idx_next   = best_idx_reg;
        best_found_next = best_found_reg;
        best_val_next   = best_val_reg;
        best_age_next   = best_age_reg;
        emit_en         = 1'b0;
        emit_action     = ACT_SEND;
        emit_mac        = '0;
        emit_ip         = '0;
        emit_handle     = '0;
        emit_last       = 1'b1;
        for (int i = 0; i < ARC_CELLS; i++)
            we_arr[i] = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end

            S_DECODE:
            begin
                unique case (arc_func_t'(func_reg))
                    FUNC_SEND:
                    begin
                        if (|cache_hit_vec)
                        begin
                            if (out_free)
                            begin
                                emit_en     = 1'b1;
                                emit_action = ACT_SEND;
                                emit_mac    = hit_mac;
                                emit_ip     = q_ip_reg;
                                emit_handle = handle_reg;
                                state_next  = S_IDLE;
                            end
                        end
                        else if ((|hold_hit_vec) && (now_reg < hit_until))
                            state_next = S_PARK;
                        else if (|hold_hit_vec)
                        begin
                            best_idx_next = hold_hit_idx;
                            state_next    = S_HFILL;
                        end
                        else if (hold_free_any)
                        begin
                            best_idx_next = hold_free_idx;
                            state_next    = S_HFILL;
                        end
                        else
                        begin
                            cur_next        = '0;
                            best_found_next = 1'b0;
                            state_next      = S_HSCAN;
                        end
                    end
                    FUNC_RX:
                    begin
                        if ((fdst_reg != own_mac_reg) && (fdst_reg != BCAST_MAC))
                            state_next = S_IDLE;
                        else if (ftype_reg == ETH_IPV4)
                        begin
                            if (out_free)
                            begin
                                emit_en     = 1'b1;
                                emit_action = ACT_DELIVER;
                                emit_handle = handle_reg;
                                state_next  = S_IDLE;
                            end
                        end
                        else if (ftype_reg == ETH_ARP)
                        begin
                            if (|cache_hit_vec)
                            begin
                                best_idx_next = cache_hit_idx;
                                state_next    = S_CFILL;
                            end
                            else if (cache_free_any)
                            begin
                                best_idx_next = cache_free_idx;
                                state_next    = S_CFILL;
                            end
                            else
                            begin
                                cur_next        = '0;
                                best_found_next = 1'b0;
                                state_next      = S_CSCAN;
                            end
                        end
                        else
                            state_next = S_IDLE;
                    end
                    FUNC_TICK:
                        state_next = S_TICK_ADD;
                    default:
                        state_next = S_IDLE;
                endcase
            end

            // Oldest hold deadline, lowest index on ties.
            S_HSCAN:
            begin
                if (!best_found_reg || (stat_arr[cur_reg].hold_until < best_val_reg))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = cur_reg;
                    best_val_next   = stat_arr[cur_reg].hold_until;
                end
                cur_next = cur_reg + 1'b1;
                if (cur_last)
                    state_next = S_HFILL;
            end

            S_HFILL:
            begin
                we_arr[best_idx_reg].hold_we = 1'b1;
                state_next = S_REQ;
            end

            S_REQ:
            begin
                if (out_free)
                begin
                    emit_en     = 1'b1;
                    emit_action = ACT_REQUEST;
                    emit_mac    = BCAST_MAC;
                    emit_ip     = q_ip_reg;
                    emit_last   = pend_free_any;
                    state_next  = S_PARK;
                end
            end

            S_PARK:
            begin
                if (pend_free_any)
                begin
                    we_arr[pend_free_idx].pend_we = 1'b1;
                    stamp_next = stamp_reg + 16'd1;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    emit_en     = 1'b1;
                    emit_action = ACT_DROP;
                    emit_ip     = q_ip_reg;
                    emit_handle = handle_reg;
                    state_next  = S_IDLE;
                end
            end

            // Earliest cache expiry, lowest index on ties.
            S_CSCAN:
            begin
                if (!best_found_reg || (stat_arr[cur_reg].cache_exp < best_val_reg))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = cur_reg;
                    best_val_next   = stat_arr[cur_reg].cache_exp;
                end
                cur_next = cur_reg + 1'b1;
                if (cur_last)
                    state_next = S_CFILL;
            end

            S_CFILL:
            begin
                we_arr[best_idx_reg].cache_we = 1'b1;
                state_next = S_REL;
            end

            S_REL:
            begin
                cur_next        = '0;
                best_found_next = 1'b0;
                if (|pend_hit_vec)
                    state_next = S_RSCAN;
                else
                    state_next = S_REPLY;
            end

            // Oldest parked item of the sender address.
            S_RSCAN:
            begin
                if (stat_arr[cur_reg].pend_hit && (!best_found_reg || (cur_age > best_age_reg)))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = cur_reg;
                    best_age_next   = cur_age;
                end
                cur_next = cur_reg + 1'b1;
                if (cur_last)
                    state_next = S_RELEMIT;
            end

            S_RELEMIT:
            begin
                if (out_free)
                begin
                    emit_en     = 1'b1;
                    emit_action = ACT_SEND;
                    emit_mac    = smac_reg;
                    emit_ip     = q_ip_reg;
                    emit_handle = stat_arr[best_idx_reg].pend_handle;
                    emit_last   = ($countones(pend_hit_vec) == 1) && !reply_due;
                    we_arr[best_idx_reg].pend_clr = 1'b1;
                    state_next  = S_REL;
                end
            end

            S_REPLY:
            begin
                if (!reply_due)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    emit_en     = 1'b1;
                    emit_action = ACT_REPLY;
                    emit_mac    = smac_reg;
                    emit_ip     = q_ip_reg;
                    state_next  = S_IDLE;
                end
            end

            S_TICK_ADD:
            begin
                now_next   = now_reg + 64'(elapsed_reg);
                state_next = S_TICK_EXP;
            end

            S_TICK_EXP:
                state_next = S_IDLE;

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            stamp_reg      <= '0;
            out_valid_reg  <= 1'b0;
            own_mac_reg    <= '0;
            own_ip_reg     <= '0;
            ttl_reg        <= TTL_RESET;
            hold_ms_reg    <= HOLD_RESET;
            best_found_reg <= 1'b0;
            cur_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            stamp_reg      <= stamp_next;
            best_found_reg <= best_found_next;
            cur_reg        <= cur_next;
            if (emit_en)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (arc_reg_t'(cfg_index))
                    REG_OWN_MAC: own_mac_reg <= cfg_data;
                    REG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                    REG_TTL:     ttl_reg     <= cfg_data[31:0];
                    REG_HOLD:    hold_ms_reg <= cfg_data[31:0];
                    default:     ;
                endcase
            end
        end
    end

    // Item fields, scan results and the output register.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg    <= func;
            q_ip_reg    <= (arc_func_t'(func) == FUNC_SEND) ? next_hop_ip : arp_sender_ip;
            handle_reg  <= packet_handle;
            fdst_reg    <= frame_dst_mac;
            ftype_reg   <= frame_type;
            opcode_reg  <= arp_opcode;
            smac_reg    <= arp_sender_mac;
            tip_reg     <= arp_target_ip;
            elapsed_reg <= elapsed_ms;
        end
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        best_age_reg <= best_age_next;
        if (emit_en)
        begin
            out_action_reg <= emit_action;
            out_mac_reg    <= emit_mac;
            out_ip_reg     <= emit_ip;
            out_handle_reg <= emit_handle;
            out_last_reg   <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = out_action_reg;
    assign dst_mac    = out_mac_reg;
    assign dest_ip    = out_ip_reg;
    assign out_handle = out_handle_reg;
    assign last       = out_last_reg;

    // An address is held in at most one cache entry and one hold entry.
    `ARC_ASSERT(a_cache_unique, $onehot0(cache_hit_vec))
    `ARC_ASSERT(a_hold_unique, $onehot0(hold_hit_vec))
    // A release always points at a parked item of the sender address.
    `ARC_ASSERT(a_release_hit, (state_reg == S_RELEMIT) |-> pend_hit_vec[best_idx_reg])
    // A result is never loaded over one that is still waiting.
    `ARC_NEVER(a_no_overwrite, emit_en && out_valid_reg && !out_ready)

endmodule

@@ rtl/core/arc_cell.sv @@
// ============================================================================
// ARP cache cell
// Holds one cache entry, one hold entry and one pending entry, compares
// them with the query address and ripples the free-entry search onwards.
// ============================================================================
module arc_cell
    import arc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arc_cmd_t   cmd,
    input  arc_we_t    we,
    input  arc_chain_t chain_in,
    output arc_chain_t chain_out,
    output arc_stat_t  stat
);

    logic        cache_valid_reg;
    logic [31:0] cache_ip_reg;
    logic [47:0] cache_mac_reg;
    logic [63:0] cache_exp_reg;
    logic        hold_valid_reg;
    logic [31:0] hold_ip_reg;
    logic [63:0] hold_until_reg;
    logic        pend_valid_reg;
    logic [31:0] pend_ip_reg;
    logic [15:0] pend_handle_reg;
    logic [15:0] pend_stamp_reg;

    // Valid bits: set on a write, cleared by expiry at a tick or by release.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_valid_reg <= 1'b0;
            hold_valid_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            if (we.cache_we)
                cache_valid_reg <= 1'b1;
            else if (cmd.tick && (cmd.now >= cache_exp_reg))
                cache_valid_reg <= 1'b0;

            if (we.hold_we)
                hold_valid_reg <= 1'b1;
            else if (cmd.tick && (cmd.now >= hold_until_reg))
                hold_valid_reg <= 1'b0;

            if (we.pend_we)
                pend_valid_reg <= 1'b1;
            else if (we.pend_clr)
                pend_valid_reg <= 1'b0;
        end
    end

    // Entry contents carry no reset; they are read only behind a valid bit.
    always_ff @(posedge clk)
    begin
        if (we.cache_we)
        begin
            cache_ip_reg  <= cmd.q_ip;
            cache_mac_reg <= cmd.mac;
            cache_exp_reg <= cmd.cache_exp;
        end
        if (we.hold_we)
        begin
            hold_ip_reg    <= cmd.q_ip;
            hold_until_reg <= cmd.hold_until;
        end
        if (we.pend_we)
        begin
            pend_ip_reg     <= cmd.q_ip;
            pend_handle_reg <= cmd.handle;
            pend_stamp_reg  <= cmd.stamp;
        end
    end

    // The lowest free entry is the first one not preceded by another.
    assign chain_out.cache_seen = chain_in.cache_seen | ~cache_valid_reg;
    assign chain_out.hold_seen  = chain_in.hold_seen  | ~hold_valid_reg;
    assign chain_out.pend_seen  = chain_in.pend_seen  | ~pend_valid_reg;

    always_comb
    begin
        stat.cache_hit        = cache_valid_reg && (cache_ip_reg == cmd.q_ip);
        stat.hold_hit         = hold_valid_reg && (hold_ip_reg == cmd.q_ip);
        stat.pend_hit         = pend_valid_reg && (pend_ip_reg == cmd.q_ip);
        stat.cache_first_free = ~cache_valid_reg & ~chain_in.cache_seen;
        stat.hold_first_free  = ~hold_valid_reg & ~chain_in.hold_seen;
        stat.pend_first_free  = ~pend_valid_reg & ~chain_in.pend_seen;
        stat.cache_mac        = cache_mac_reg;
        stat.cache_exp        = cache_exp_reg;
        stat.hold_until       = hold_until_reg;
        stat.pend_handle      = pend_handle_reg;
        stat.pend_stamp       = pend_stamp_reg;
    end

endmodule

@@ verif/tb_arp_resolution_cache.sv @@
// ============================================================================
// ARP resolution cache testbench
// Drives sends, received frames and ticks through the valid/ready channels,
// predicts every result from a behavioural copy of the cache, hold and
// pending tables, and checks each result field by field in order.
// ============================================================================
module tb_arp_resolution_cache;
    import arc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One expected or observed result.
    typedef struct {
        logic [2:0]  act;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] hdl;
        logic        lst;
    } arp_result_t;

    // One input item.
    typedef struct {
        arc_func_t   fn;
        logic [31:0] hop;
        logic [15:0] hdl;
        logic [47:0] dmac;
        logic [15:0] etype;
        logic [15:0] op;
        logic [47:0] smac;
        logic [31:0] sip;
        logic [31:0] tip;
        logic [15:0] dt;
    } arp_item_t;

    // Behavioural copy of the resolver and the queue of results it expects.
    class arp_scoreboard;
        logic [47:0] my_mac;
        logic [31:0] my_ip;
        logic [31:0] ttl;
        logic [31:0] hold_ms;
        logic [63:0] clock_ms;
        bit          c_ok[16];
        logic [31:0] c_ip[16];
        logic [47:0] c_mac[16];
        logic [63:0] c_exp[16];
        bit          h_ok[16];
        logic [31:0] h_ip[16];
        logic [63:0] h_until[16];
        bit          p_ok[16];
        logic [31:0] p_ip[16];
        logic [15:0] p_hdl[16];
        logic [15:0] p_stamp[16];
        logic [15:0] stamp_ctr;
        arp_result_t pending_results[$];
        int          mismatches;
        int          checked;

        function void clear();
            my_mac = '0;
            my_ip = '0;
            ttl = TTL_RESET;
            hold_ms = HOLD_RESET;
            clock_ms = '0;
            stamp_ctr = '0;
            for (int i = 0; i < 16; i++)
            begin
                c_ok[i] = 0;
                h_ok[i] = 0;
                p_ok[i] = 0;
            end
        endfunction

        function void write_reg(arc_reg_t idx, logic [47:0] val);
            case (idx)
                REG_OWN_MAC: my_mac = val;
                REG_OWN_IP:  my_ip = val[31:0];
                REG_TTL:     ttl = val[31:0];
                REG_HOLD:    hold_ms = val[31:0];
                default: ;
            endcase
        endfunction

        function void push(arc_action_t a, logic [47:0] m, logic [31:0] ip,
                           logic [15:0] h);
            arp_result_t r;
            r.act = a;
            r.mac = m;
            r.ip = ip;
            r.hdl = h;
            r.lst = 0;
            pending_results.push_back(r);
        endfunction

        function int cache_lookup(logic [31:0] ip);
            for (int i = 0; i < 16; i++)
                if (c_ok[i] && c_ip[i] == ip) return i;
            return -1;
        endfunction

        function void learn(logic [31:0] ip, logic [47:0] mac);
            int slot;
            slot = cache_lookup(ip);
            if (slot < 0)
                for (int i = 0; i < 16; i++)
                    if (!c_ok[i])
                    begin
                        slot = i;
                        break;
                    end
            if (slot < 0)
            begin
                slot = 0;
                for (int i = 1; i < 16; i++)
                    if (c_exp[i] < c_exp[slot]) slot = i;
            end
            c_ok[slot] = 1;
            c_ip[slot] = ip;
            c_mac[slot] = mac;
            c_exp[slot] = clock_ms + 64'(ttl);
        endfunction

        // Returns 1 when a request may go out now, and rearms the window.
        function bit request_allowed(logic [31:0] ip);
            int slot;
            slot = -1;
            for (int i = 0; i < 16; i++)
                if (h_ok[i] && h_ip[i] == ip)
                begin
                    slot = i;
                    break;
                end
            if (slot >= 0 && clock_ms < h_until[slot]) return 0;
            if (slot < 0)
                for (int i = 0; i < 16; i++)
                    if (!h_ok[i])
                    begin
                        slot = i;
                        break;
                    end
            if (slot < 0)
            begin
                slot = 0;
                for (int i = 1; i < 16; i++)
                    if (h_until[i] < h_until[slot]) slot = i;
            end
            h_ok[slot] = 1;
            h_ip[slot] = ip;
            h_until[slot] = clock_ms + 64'(hold_ms);
            return 1;
        endfunction

        function void resolve_send(logic [31:0] ip, logic [15:0] h);
            int c;
            c = cache_lookup(ip);
            if (c >= 0)
            begin
                push(ACT_SEND, c_mac[c], ip, h);
                return;
            end
            if (request_allowed(ip)) push(ACT_REQUEST, BCAST_MAC, ip, 16'd0);
            for (int i = 0; i < 16; i++)
                if (!p_ok[i])
                begin
                    p_ok[i] = 1;
                    p_ip[i] = ip;
                    p_hdl[i] = h;
                    p_stamp[i] = stamp_ctr;
                    stamp_ctr++;
                    return;
                end
            push(ACT_DROP, 48'd0, ip, h);
        endfunction

        // Notes an accepted input item and queues its expected results.
        function void note_item(arp_item_t it);
            int n0;
            int best;
            logic [15:0] best_age;
            logic [15:0] age;
            n0 = pending_results.size();
            case (it.fn)
                FUNC_SEND: resolve_send(it.hop, it.hdl);
                FUNC_RX:
                    if (it.dmac == my_mac || it.dmac == BCAST_MAC)
                    begin
                        if (it.etype == ETH_IPV4)
                            push(ACT_DELIVER, 48'd0, 32'd0, it.hdl);
                        else if (it.etype == ETH_ARP)
                        begin
                            learn(it.sip, it.smac);
                            forever
                            begin
                                best = -1;
                                best_age = '0;
                                for (int i = 0; i < 16; i++)
                                    if (p_ok[i] && p_ip[i] == it.sip)
                                    begin
                                        age = stamp_ctr - p_stamp[i];
                                        if (best < 0 || age > best_age)
                                        begin
                                            best = i;
                                            best_age = age;
                                        end
                                    end
                                if (best < 0) break;
                                p_ok[best] = 0;
                                resolve_send(it.sip, p_hdl[best]);
                            end
                            if (it.op == ARP_OP_REQ && it.tip == my_ip)
                                push(ACT_REPLY, it.smac, it.sip, 16'd0);
                        end
                    end
                FUNC_TICK:
                begin
                    clock_ms += 64'(it.dt);
                    for (int i = 0; i < 16; i++)
                    begin
                        if (c_ok[i] && clock_ms >= c_exp[i]) c_ok[i] = 0;
                        if (h_ok[i] && clock_ms >= h_until[i]) h_ok[i] = 0;
                    end
                end
                default: ;
            endcase
            if (pending_results.size() > n0)
                pending_results[pending_results.size() - 1].lst = 1;
        endfunction

        // Compares one observed result with the oldest expectation.
        function void check_result(arp_result_t got);
            arp_result_t exp_r;
            checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result act=%0d mac=%h ip=%h h=%h last=%0b",
                             got.act, got.mac, got.ip, got.hdl, got.lst);
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.act !== exp_r.act || got.mac !== exp_r.mac || got.ip !== exp_r.ip
                || got.hdl !== exp_r.hdl || got.lst !== exp_r.lst)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected act=%0d mac=%h ip=%h h=%h last=%0b, %s",
                             exp_r.act, exp_r.mac, exp_r.ip, exp_r.hdl, exp_r.lst,
                             $sformatf("got act=%0d mac=%h ip=%h h=%h last=%0b",
                                       got.act, got.mac, got.ip, got.hdl, got.lst));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [31:0] next_hop_ip;
    logic [15:0] packet_handle;
    logic [47:0] frame_dst_mac;
    logic [15:0] frame_type;
    logic [15:0] arp_opcode;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_sender_ip;
    logic [31:0] arp_target_ip;
    logic [15:0] elapsed_ms;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  action;
    logic [47:0] dst_mac;
    logic [31:0] dest_ip;
    logic [15:0] out_handle;
    logic        last;

    arp_scoreboard sb;
    longint unsigned cycle_count;
    bit              hold_off_req;
    int              results_seen;

    // Small pools of addresses so that sends, ARP frames and hold windows meet.
    logic [31:0] hop_pool[8];
    logic [47:0] mac_pool[8];

    arp_resolution_cache i_dut (.*);

    // Clock.
    initial clk = 0;
    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // Cycle limit guards against a hang.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_arp_resolution_cache: errors");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request.
    initial
    begin
        int gap;
        out_ready = 0;
        wait (rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 0;
                repeat (300) @(posedge clk);
                hold_off_req = 0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
                  (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
            if (gap > 0)
            begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Result monitor: samples the values that held just before the edge.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
        begin
            arp_result_t r;
            r.act = action;
            r.mac = dst_mac;
            r.ip = dest_ip;
            r.hdl = out_handle;
            r.lst = last;
            sb.check_result(r);
            results_seen++;
        end

    // Valid stays high between back-to-back writes; the caller drops it.
    task automatic write_cfg(arc_reg_t idx, logic [47:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Valid stays high into the next item; gaps and drains drop it.
    task automatic send_item(arp_item_t it);
        in_valid <= 1;
        func <= it.fn;
        next_hop_ip <= it.hop;
        packet_handle <= it.hdl;
        frame_dst_mac <= it.dmac;
        frame_type <= it.etype;
        arp_opcode <= it.op;
        arp_sender_mac <= it.smac;
        arp_sender_ip <= it.sip;
        arp_target_ip <= it.tip;
        elapsed_ms <= it.dt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(it);
    endtask

    // Random gap before an item, mostly none.
    task automatic sender_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7) in_valid <= 0;
        if (r == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
        else if (r < 7) repeat ($urandom_range(1, 3)) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        // A received frame with no result may still be running.
        repeat (300) @(posedge clk);
    endtask

    function automatic arp_item_t blank_item();
        arp_item_t it;
        it.fn = FUNC_NOP;
        it.hop = $urandom;
        it.hdl = 16'($urandom);
        it.dmac = 48'({$urandom, $urandom});
        it.etype = 16'($urandom);
        it.op = 16'($urandom);
        it.smac = 48'({$urandom, $urandom});
        it.sip = $urandom;
        it.tip = $urandom;
        it.dt = 16'($urandom);
        return it;
    endfunction

    function automatic arp_item_t mk_send(logic [31:0] ip, logic [15:0] h);
        arp_item_t it;
        it = blank_item();
        it.fn = FUNC_SEND;
        it.hop = ip;
        it.hdl = h;
        return it;
    endfunction

    function automatic arp_item_t mk_arp(logic [47:0] dmac, logic [15:0] op,
                                         logic [47:0] smac, logic [31:0] sip,
                                         logic [31:0] tip);
        arp_item_t it;
        it = blank_item();
        it.fn = FUNC_RX;
        it.dmac = dmac;
        it.etype = ETH_ARP;
        it.op = op;
        it.smac = smac;
        it.sip = sip;
        it.tip = tip;
        return it;
    endfunction

    function automatic arp_item_t mk_tick(logic [15:0] dt);
        arp_item_t it;
        it = blank_item();
        it.fn = FUNC_TICK;
        it.dt = dt;
        return it;
    endfunction

    // Random item, mostly well-formed traffic over the address pools.
    function automatic arp_item_t random_item();
        arp_item_t it;
        int k;
        int p;
        p = $urandom_range(0, 7);
        k = $urandom_range(0, 99);
        if (k < 40) it = mk_send(($urandom_range(0, 9) == 0) ? $urandom : hop_pool[p],
                                 16'($urandom));
        else if (k < 65)
        begin
            it = mk_arp(($urandom_range(0, 1) == 0) ? BCAST_MAC : sb.my_mac,
                        16'($urandom_range(1, 2)), mac_pool[p], hop_pool[p],
                        ($urandom_range(0, 1) == 0) ? sb.my_ip : $urandom);
            if ($urandom_range(0, 9) == 0) it.op = 16'($urandom);
        end
        else if (k < 75)
        begin
            it = blank_item();
            it.fn = FUNC_RX;
            it.dmac = ($urandom_range(0, 1) == 0) ? sb.my_mac : it.dmac;
            it.etype = ETH_IPV4;
        end
        else if (k < 88) it = mk_tick(($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                      16'($urandom_range(0, 3000)));
        else
        begin
            // Noise: foreign MACs, odd ethertypes and the unused function code.
            it = blank_item();
            it.fn = arc_func_t'($urandom_range(1, 3));
            if ($urandom_range(0, 1) == 0) it.dmac = sb.my_mac;
        end
        return it;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            sender_gap();
            send_item(random_item());
        end
    endtask

    initial
    begin
        arp_item_t it;
        sb = new();
        sb.clear();
        sb.mismatches = 0;
        sb.checked = 0;
        cycle_count = 0;
        hold_off_req = 0;
        results_seen = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = REG_OWN_MAC;
        cfg_data = '0;
        in_valid = 0;
        func = FUNC_NOP;
        next_hop_ip = '0;
        packet_handle = '0;
        frame_dst_mac = '0;
        frame_type = '0;
        arp_opcode = '0;
        arp_sender_mac = '0;
        arp_sender_ip = '0;
        arp_target_ip = '0;
        elapsed_ms = '0;
        for (int i = 0; i < 8; i++)
        begin
            hop_pool[i] = $urandom;
            mac_pool[i] = 48'({$urandom, $urandom});
        end
        hop_pool[0] = '0;
        hop_pool[1] = '1;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part at reset settings: miss, hold window, learn, release.
        send_item(mk_send(hop_pool[2], 16'h0000));
        send_item(mk_send(hop_pool[2], 16'hFFFF));
        send_item(mk_send(hop_pool[3], 16'h1234));
        send_item(mk_arp(48'd0, 16'd2, mac_pool[2], hop_pool[2], 32'd0));
        send_item(mk_send(hop_pool[2], 16'h5555));
        send_item(mk_arp(BCAST_MAC, ARP_OP_REQ, 48'hFFFF_FFFF_FFFF, hop_pool[1],
                         32'd0));
        send_item(mk_arp(48'h1, ARP_OP_REQ, mac_pool[4], hop_pool[4], 32'd0));
        it = blank_item();
        it.fn = FUNC_RX;
        it.dmac = BCAST_MAC;
        it.etype = ETH_IPV4;
        it.hdl = 16'hFFFF;
        send_item(it);
        it.fn = FUNC_NOP;
        send_item(it);
        it.fn = FUNC_RX;
        it.etype = 16'hFFFF;
        send_item(it);
        // Fill the pending store past its depth to force drops.
        for (int i = 0; i < 17; i++) send_item(mk_send(32'h0A00_0000 + 32'(i), 16'(i)));
        send_item(mk_tick(16'hFFFF));
        send_item(mk_tick(16'd0));
        send_item(mk_send(hop_pool[2], 16'hA5A5));
        drain();

        // Extremes of the registers, then random traffic in several phases.
        write_cfg(REG_OWN_MAC, '1);
        write_cfg(REG_OWN_IP, '1);
        write_cfg(REG_TTL, 48'd1);
        write_cfg(REG_HOLD, 48'd1);
        cfg_valid <= 0;
        run_random(50);
        drain();

        write_cfg(REG_OWN_MAC, 48'({$urandom, $urandom}));
        write_cfg(REG_OWN_IP, 48'(hop_pool[5]));
        write_cfg(REG_TTL, 48'hFFFF_FFFF);
        write_cfg(REG_HOLD, 48'hFFFF_FFFF);
        cfg_valid <= 0;
        // Receiver holds off while the sender keeps offering items.
        hold_off_req = 1;
        run_random(60);
        drain();

        write_cfg(REG_OWN_MAC, 48'd0);
        write_cfg(REG_OWN_IP, 48'd0);
        write_cfg(REG_TTL, 48'($urandom_range(2000, 20000)));
        write_cfg(REG_HOLD, 48'($urandom_range(500, 4000)));
        cfg_valid <= 0;
        run_random(100);
        drain();

        $display("covered %0d results over directed and random sends, ARP frames, ticks",
                 sb.checked);
        $display("register settings included all-ones addresses and minimum/maximum timers");
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("tb_arp_resolution_cache: clean");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_results.size());
            $display("tb_arp_resolution_cache: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/arc_pkg.sv
rtl/core/arc_cell.sv
rtl/core/arp_resolution_cache.sv
verif/tb_arp_resolution_cache.sv
